// File: rtl/qpb64_pkg.sv
// Shared types, codes and character lookups for the quoted-printable / base64 decoder.
`timescale 1ns / 1ps
package qpb64_pkg;

	localparam logic [31:0] MAX_COUNT = 32'd65535;
	localparam logic [15:0] COUNT_LIMIT =
		(MAX_COUNT > 32'd65535) ? 16'hFFFF : MAX_COUNT[15:0];

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 16;
	localparam int TDATA_W = 32;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_QP   = 2'd1,
		MODE_B64  = 2'd2,
		MODE_RSVD = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_BADESC = 2'd1,
		STATUS_UNSUP  = 2'd2,
		STATUS_RSVD   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_NORMAL = 3'b001,
		PH_EQ     = 3'b010,
		PH_HEX    = 3'b100
	} qp_phase_t;

	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// {hit, nibble}
	function automatic logic [4:0] hex_lookup(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c inside {[8'h61:8'h66]}) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c inside {[8'h41:8'h46]}) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	// {hit, 6-bit code}
	function automatic logic [6:0] b64_lookup(input logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		if (c inside {[8'h41:8'h5A]}) begin
			r = {1'b1, 6'(c - 8'h41)};
		end else if (c inside {[8'h61:8'h7A]}) begin
			r = {1'b1, 6'(c - 8'h47)};
		end else if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, 6'(c + 8'h04)};
		end else if (c == 8'h2B) begin
			r = {1'b1, 6'd62};
		end else if (c == 8'h2F) begin
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

endpackage

// File: rtl/qp_base64_body_decoder_core.sv
// Quoted-printable / base64 body decoder: input register, decode logic, result register.
//
// Usage:
//   s_axis carries one encoded character per item in tdata[7:0]; a zero byte ends the text.
//   m_axis carries results: tlast low is a decoded byte, tlast high is the end-of-text
//   status item that closes the text (status and saturating byte count in tdata).
//   cfg_* writes the decode mode (1 quoted-printable, 2 base64, 0 or 3 unsupported);
//   cfg_ready is always high. Write it only while no text item is in flight.
//   Path: an accepted item passes the input register, then the decode logic, then the result
//   register. Throughput: one item per cycle while the receiver does not stall, bounded by
//   the combinational decode and state update between the two registers.
//   Items that cause no result (escape bytes, skipped characters, bytes after an error)
//   vanish after the input register.
//   Reset: mode returns to quoted-printable, all decode state clears, both registers empty.
//   Receiver stall: the result register holds; the input register still accepts one item,
//   then s_axis_tready drops until the result is taken.
`timescale 1ns / 1ps
module qp_base64_body_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [9:8] status, [25:10] byte_count
	output logic        m_axis_tlast,   // result_kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data        // decode_mode
);
	import qpb64_pkg::*;

	mode_t                 mode_q;
	logic                  valid_s1;
	logic [BYTE_W-1:0]     byte_s1;
	qp_phase_t             phase_q, phase_n;
	logic [3:0]            nib_q, nib_n;
	logic [12:0]           acc_q, acc_n;
	logic [3:0]            bits_q, bits_n;
	status_t               err_q, err_n;
	logic [COUNT_W-1:0]    cnt_q, cnt_n;

	logic                  out_valid_q;
	logic [BYTE_W-1:0]     out_byte_q;
	logic                  out_last_q;
	status_t               out_status_q;
	logic [COUNT_W-1:0]    out_count_q;

	logic                  advance;
	logic                  emit;
	logic                  emit_last;
	logic [BYTE_W-1:0]     emit_byte;
	status_t               emit_status;
	logic                  supported;
	logic [4:0]            hex;
	logic [6:0]            b64;
	logic [12:0]           acc_shift;
	logic [3:0]            bits_sum;
	logic [COUNT_W-1:0]    cnt_inc;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign supported = (mode_q == MODE_QP) || (mode_q == MODE_B64);
	assign hex       = hex_lookup(byte_s1);
	assign b64       = b64_lookup(byte_s1);
	assign acc_shift = {acc_q[6:0], b64[5:0]};
	assign bits_sum  = bits_q + 4'd6;
	assign cnt_inc   = (cnt_q < COUNT_LIMIT) ? cnt_q + 16'd1 : cnt_q;

	always_comb begin
		phase_n     = phase_q;
		nib_n       = nib_q;
		acc_n       = acc_q;
		bits_n      = bits_q;
		err_n       = err_q;
		cnt_n       = cnt_q;
		emit        = 1'b0;
		emit_last   = 1'b0;
		emit_byte   = '0;
		emit_status = STATUS_OK;
		if (byte_s1 == 8'd0) begin
			emit_status = err_q;
			if (err_q == STATUS_OK && !supported) begin
				emit_status = STATUS_UNSUP;
			end else if (err_q == STATUS_OK && mode_q == MODE_QP && phase_q != PH_NORMAL) begin
				emit_status = STATUS_BADESC;
			end
			emit      = 1'b1;
			emit_last = 1'b1;
			phase_n   = PH_NORMAL;
			nib_n     = '0;
			acc_n     = '0;
			bits_n    = '0;
			err_n     = STATUS_OK;
			cnt_n     = '0;
		end else if (err_q != STATUS_OK) begin
			// drop everything until end of text
		end else if (!supported) begin
			err_n = STATUS_UNSUP;
		end else if (mode_q == MODE_QP) begin
			case (phase_q)
				PH_NORMAL: begin
					if (byte_s1 == CH_EQ) begin
						phase_n = PH_EQ;
					end else begin
						emit      = 1'b1;
						emit_byte = byte_s1;
						cnt_n     = cnt_inc;
					end
				end
				PH_EQ: begin
					if (byte_s1 == CH_CR || byte_s1 == CH_LF) begin
						phase_n = PH_NORMAL;
					end else if (!hex[4]) begin
						err_n   = STATUS_BADESC;
						phase_n = PH_NORMAL;
					end else begin
						nib_n   = hex[3:0];
						phase_n = PH_HEX;
					end
				end
				PH_HEX: begin
					phase_n = PH_NORMAL;
					if (!hex[4]) begin
						err_n = STATUS_BADESC;
					end else begin
						emit      = 1'b1;
						emit_byte = {nib_q, hex[3:0]};
						cnt_n     = cnt_inc;
					end
				end
				default: begin
					phase_n = PH_NORMAL;
				end
			endcase
		end else if (b64[6]) begin
			acc_n = acc_shift;
			if (bits_sum >= 4'd8) begin
				bits_n    = bits_sum - 4'd8;
				emit      = 1'b1;
				emit_byte = 8'(acc_shift >> (bits_sum - 4'd8));
				cnt_n     = cnt_inc;
			end else begin
				bits_n = bits_sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_QP;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= mode_t'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			nib_q   <= '0;
			acc_q   <= '0;
			bits_q  <= '0;
			err_q   <= STATUS_OK;
			cnt_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			nib_q   <= nib_n;
			acc_q   <= acc_n;
			bits_q  <= bits_n;
			err_q   <= err_n;
			cnt_q   <= cnt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result while the receiver stalls
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_byte_q   <= emit_byte;
			out_last_q   <= emit_last;
			out_status_q <= emit_status;
			out_count_q  <= emit_last ? cnt_q : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {6'd0, out_count_q, out_status_q, out_byte_q};

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && byte_s1 == 8'd0 |=> err_q == STATUS_OK && cnt_q == '0 && bits_q == '0)
		else $error("decode state not cleared after end of text");

	a_bits_even: assert property (@(posedge clk) disable iff (!arst_n)
		!bits_q[0] && bits_q < 4'd8)
		else $error("base64 bit count out of range");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != STATUS_RSVD)
		else $error("reserved error code latched");

	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_last_q |-> out_status_q == STATUS_OK && out_count_q == '0)
		else $error("decoded byte item carries status fields");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_axis_tready |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost an item during stall");

endmodule
